// ===== hw/rtl/bole_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and defaults for the bounded ordered list engine
package bole_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int POS_W = 5;
	localparam int LEN_W = 5;
	localparam int ELEM_W = 8;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_REAR  = 3'd1,
		CMD_INS_POS   = 3'd2,
		CMD_INS_SORT  = 3'd3,
		CMD_DEL_FRONT = 3'd4,
		CMD_DEL_REAR  = 3'd5,
		CMD_DEL_POS   = 3'd6,
		CMD_DISPLAY   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t           op;
		logic               sorted;
		logic signed [7:0]  new_val;
		logic signed [7:0]  head_val;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/bole_cell.sv =====
`timescale 1ns / 1ps
// one slot of the list chain: holds a byte and shifts with its neighbours
module bole_cell import bole_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int INDEX = 0
) (
	input  logic                                   clk,
	input  cell_ctl_t                              ctl,
	input  logic [$clog2(CAPACITY)-1:0]            at,
	input  logic [$clog2(CAPACITY+1)-1:0]          occ,
	input  logic signed [ELEM_W-1:0]               left_val,
	input  logic signed [ELEM_W-1:0]               right_val,
	input  logic                                   found_in,
	output logic                                   found_out,
	output logic signed [ELEM_W-1:0]               val
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY+1);

	logic signed [ELEM_W-1:0] val_q;
	logic stop;
	logic live;
	logic last_live;

	assign live      = CNT_W'(INDEX) < occ;
	assign last_live = CNT_W'(INDEX + 1) == occ;

	// sorted: stop at first slot not greater than the new byte, or past the end
	always_comb begin
		if (ctl.sorted) begin
			stop = !live || !($signed(ctl.new_val) < $signed(val_q));
		end else begin
			stop = at == IDX_W'(INDEX);
		end
	end

	assign found_out = found_in | stop;
	assign val = val_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_INS: begin
				if (found_in) begin
					val_q <= left_val;
				end else if (stop) begin
					val_q <= ctl.new_val;
				end
			end
			CELL_DEL: begin
				if (found_in || stop) begin
					val_q <= right_val;
				end
			end
			CELL_ROT: begin
				if (last_live) begin
					val_q <= ctl.head_val;
				end else if (live) begin
					val_q <= right_val;
				end
			end
			CELL_HOLD: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/bounded_ordered_list_engine.sv =====
`timescale 1ns / 1ps
// top level of the bounded ordered list engine: command decode, cell chain, result register
//
//   channel   valid      stall      payload                         direction
//   command   cmd_valid  cmd_stall  cmd, value, position            in
//   result    res_valid  res_stall  status, element, length, last   out
//
// every insert or delete finishes in the cycle its word is accepted: the whole
// chain of cells shifts at once, so each such command gives one result word in the next cycle
// display: the accepting cycle loads the count, or answers an empty list with one EMPTY word;
// then the chain rotates one cell per cycle while the result register is free,
// and the head cell is sent out each time
// reset empties the list at once; slot contents are not cleared
// a stalled result word holds; commands are taken only while no display is
// streaming and the result register is empty or being drained
module bounded_ordered_list_engine import bole_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [2:0]               cmd,
	input  logic signed [ELEM_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [1:0]               status,
	output logic signed [ELEM_W-1:0] element,
	output logic [LEN_W-1:0]         length,
	output logic                     last
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DISP = 2'b10
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] remain_q;

	// result register
	logic                     res_valid_q;
	stat_t                    status_q;
	logic signed [ELEM_W-1:0] element_q;
	logic [LEN_W-1:0]         length_q;
	logic                     last_q;

	// cell chain
	logic signed [ELEM_W-1:0] cell_val [CAPACITY];
	logic                     found    [CAPACITY];
	cell_ctl_t                ctl;
	logic [IDX_W-1:0]         at;

	// decode
	logic                     out_free;
	logic                     accept;
	cmd_t                     cmd_c;
	logic [CMP_W-1:0]         pos_x;
	logic [CMP_W-1:0]         occ_x;
	logic                     full;
	logic                     empty;
	logic                     emit;
	stat_t                    res_status;
	logic signed [ELEM_W-1:0] res_elem;
	logic                     res_last;
	logic [CNT_W-1:0]         occ_next;
	logic [CMP_W-1:0]         len_x;
	logic                     go_disp;

	// result register is free when empty or being taken this cycle
	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = !((state_q == ST_IDLE) && out_free);
	assign accept    = cmd_valid && !cmd_stall;

	assign cmd_c = cmd_t'(cmd);
	assign pos_x = CMP_W'(position);
	assign occ_x = CMP_W'(occ_q);
	assign full  = occ_q == CNT_W'(CAPACITY);
	assign empty = occ_q == '0;

	always_comb begin
		ctl.op       = CELL_HOLD;
		ctl.sorted   = 1'b0;
		ctl.new_val  = value;
		ctl.head_val = cell_val[0];
		at           = '0;
		emit         = 1'b0;
		res_status   = STAT_OK;
		res_elem     = '0;
		res_last     = 1'b1;
		occ_next     = occ_q;
		go_disp      = 1'b0;
		if (accept) begin
			unique case (cmd_c)
				CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_POS, CMD_INS_SORT: begin
					emit = 1'b1;
					if (full) begin
						res_status = STAT_FULL;
					end else if ((cmd_c == CMD_INS_POS) && (pos_x > occ_x)) begin
						res_status = STAT_RANGE;
					end else begin
						ctl.op   = CELL_INS;
						res_elem = value;
						occ_next = occ_q + CNT_W'(1);
						unique case (cmd_c)
							CMD_INS_REAR: at = occ_x[IDX_W-1:0];
							CMD_INS_POS:  at = pos_x[IDX_W-1:0];
							CMD_INS_SORT: ctl.sorted = 1'b1;
							default:      at = '0;
						endcase
					end
				end
				CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_POS: begin
					emit = 1'b1;
					if (empty) begin
						res_status = STAT_EMPTY;
					end else if ((cmd_c == CMD_DEL_POS) && (pos_x >= occ_x)) begin
						res_status = STAT_RANGE;
					end else begin
						ctl.op   = CELL_DEL;
						occ_next = occ_q - CNT_W'(1);
						unique case (cmd_c)
							CMD_DEL_REAR: at = occ_next[IDX_W-1:0];
							CMD_DEL_POS:  at = pos_x[IDX_W-1:0];
							default:      at = '0;
						endcase
						res_elem = cell_val[at];
					end
				end
				CMD_DISPLAY: begin
					if (empty) begin
						emit       = 1'b1;
						res_status = STAT_EMPTY;
					end else begin
						go_disp = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if ((state_q == ST_DISP) && out_free) begin
			// send the head and rotate it round to the tail
			ctl.op   = CELL_ROT;
			emit     = 1'b1;
			res_elem = cell_val[0];
			res_last = remain_q == CNT_W'(1);
		end
	end

	assign len_x = CMP_W'(occ_next);

	// chain of cells, slot 0 is the front
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [ELEM_W-1:0] left_w;
		logic signed [ELEM_W-1:0] right_w;
		logic                     found_in_w;

		if (i == 0) begin : g_first
			assign left_w     = '0;
			assign found_in_w = 1'b0;
		end else begin : g_inner
			assign left_w     = cell_val[i-1];
			assign found_in_w = found[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_body
			assign right_w = cell_val[i+1];
		end

		bole_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.at        (at),
			.occ       (occ_q),
			.left_val  (left_w),
			.right_val (right_w),
			.found_in  (found_in_w),
			.found_out (found[i]),
			.val       (cell_val[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			remain_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_next;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (go_disp) begin
						state_q  <= ST_DISP;
						remain_q <= occ_q;
					end
				end
				ST_DISP: begin
					if (out_free) begin
						remain_q <= remain_q - CNT_W'(1);
						if (remain_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= res_status;
			element_q <= res_elem;
			length_q  <= len_x[LEN_W-1:0];
			last_q    <= res_last;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign length    = length_q;
	assign last      = last_q;

endmodule
